// ----- rtl/core/sss_pkg.sv -----
// Shared types, codes and the segment pattern table for the display scanner.
package sss_pkg;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned EVT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_BLINK = 2'd1,
    OP_WRITE = 2'd2
  } op_e_t;

  typedef enum logic [1:0] {
    BLANK_ALL   = 2'd0,
    BLANK_HIGH  = 2'd1,
    BLANK_LOW   = 2'd2,
    BLANK_MID   = 2'd3
  } blank_grp_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_EN   = 1'b1;

  localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
  localparam logic [EVT_W-1:0] EVT_RIGHT = 2'd1;
  localparam logic [EVT_W-1:0] EVT_LEFT  = 2'd2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

  typedef struct packed {
    op_e_t             op;
    logic              pin_a;
    logic              pin_b;
    logic              pin_button;
    logic [POS_W-1:0]  digit_index;
    logic [CODE_W-1:0] digit_value;
  } item_t;

  typedef struct packed {
    logic              button_pressed;
    logic [EVT_W-1:0]  encoder_event;
    logic [POS_W-1:0]  digit_select;
    logic [SEG_W-1:0]  segments;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 8'b1111_1100;
      4'd1:    seg = 8'b0110_0000;
      4'd2:    seg = 8'b1101_1010;
      4'd3:    seg = 8'b1111_0010;
      4'd4:    seg = 8'b0110_0110;
      4'd5:    seg = 8'b1011_0110;
      4'd6:    seg = 8'b1011_1110;
      4'd7:    seg = 8'b1110_0000;
      4'd8:    seg = 8'b1111_1110;
      4'd9:    seg = 8'b1111_0110;
      4'd11:   seg = 8'b1001_1110;
      4'd12:   seg = 8'b0000_0010;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/core/sss_core.sv -----
// Display and encoder state with the per-request decode logic.
module sss_core
  import sss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    req_go,
  input  item_t   req,
  output logic    res_vld,
  output res_t    res
);

  logic [CODE_W-1:0] digit_store_r [NUM_DIGITS];
  logic [POS_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic              phase_r, phase_nxt;
  logic              prev_b_r, prev_btn_r;
  blank_grp_t        blink_mode_r;
  logic              blink_en_r;

  logic [POS_W-1:0]  pos;
  logic              phase_eff;
  logic              in_grp;
  logic [EVT_W-1:0]  evt;
  logic              press;
  logic              is_scan;

  assign is_scan   = req_go && (req.op == OP_SCAN);
  assign pos       = (scan_pos_r > LAST_POS) ? '0 : scan_pos_r;
  assign phase_eff = blink_en_r ? phase_r : 1'b1;

  always_comb begin
    unique case (blink_mode_r)
      BLANK_ALL:  in_grp = 1'b1;
      BLANK_HIGH: in_grp = (pos == 3'd3) || (pos == 3'd4);
      BLANK_LOW:  in_grp = (pos == 3'd0) || (pos == 3'd1);
      BLANK_MID:  in_grp = (pos == 3'd2);
      default:    in_grp = 1'b0;
    endcase
  end

  // Quadrature step on A low, judged against the last sampled B level
  always_comb begin
    evt = EVT_NONE;
    if (!req.pin_a && !req.pin_b && prev_b_r) begin
      evt = EVT_RIGHT;
    end else if (!req.pin_a && req.pin_b && !prev_b_r) begin
      evt = EVT_LEFT;
    end
  end

  assign press = !req.pin_button && prev_btn_r;

  assign scan_pos_nxt = (pos == LAST_POS) ? '0 : pos + POS_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    if (cfg.we && (cfg.index == CFG_BLINK_EN) && !cfg.wdata[0]) begin
      phase_nxt = 1'b1;
    end
    if (req_go) begin
      case (req.op)
        OP_BLINK: phase_nxt = blink_en_r ? !phase_r : 1'b1;
        OP_SCAN:  if (evt != EVT_NONE) phase_nxt = 1'b1;
        default:  ;
      endcase
    end
  end

  always_comb begin
    res.segments       = (!in_grp || phase_eff) ? seg_of(digit_store_r[pos]) : '0;
    res.digit_select   = pos;
    res.encoder_event  = evt;
    res.button_pressed = press;
  end
  assign res_vld = is_scan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_store_r[i] <= '0;
      end
      scan_pos_r   <= '0;
      phase_r      <= 1'b0;
      prev_b_r     <= 1'b1;
      prev_btn_r   <= 1'b1;
      blink_mode_r <= BLANK_MID;
      blink_en_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (cfg.we) begin
        unique case (cfg.index)
          CFG_BLINK_MODE: blink_mode_r <= blank_grp_t'(cfg.wdata);
          CFG_BLINK_EN:   blink_en_r   <= cfg.wdata[0];
          default:        ;
        endcase
      end
      if (req_go && (req.op == OP_WRITE) && (req.digit_index <= LAST_POS)) begin
        digit_store_r[req.digit_index] <= req.digit_value;
      end
      if (is_scan) begin
        scan_pos_r <= scan_pos_nxt;
        prev_b_r   <= req.pin_b;
        prev_btn_r <= req.pin_button;
      end
    end
  end

endmodule

// ----- rtl/core/seven_segment_scan_with_encoder.sv -----
// Top level: input register, decode core and result register of the display scanner.
// A scan request shows on out_tvalid in the cycle after it leaves the input register.
// Once accepted, a scan request passes the input register, then the result register.
// One request per cycle bar the hold below; blink ticks and writes give no result.
// Hold a scan request in the input register only while an unread result waits.
// Synchronous active-low reset clears the digits, scan position and blink phase,
// sets the encoder and button history high, blink_mode to 3 and blink_enable to 0.
module seven_segment_scan_with_encoder
  import sss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] pin_a, [1] pin_b, [2] pin_button, [5:3] digit_index, [9:6] digit_value
  input  logic [15:0]           in_tdata,
  // [1:0] op
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] segments, [10:8] digit_select, [12:11] encoder_event, [13] button_pressed
  output logic [15:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic    s1_vld_r;
  item_t   s1_item_r;
  logic    s1_go;
  logic    out_vld_r;
  res_t    out_res_r;
  logic    res_vld;
  res_t    res;
  cfg_wr_t cfg;
  item_t   in_item;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  assign in_item.op          = op_e_t'(in_tuser);
  assign in_item.pin_a       = in_tdata[0];
  assign in_item.pin_b       = in_tdata[1];
  assign in_item.pin_button  = in_tdata[2];
  assign in_item.digit_index = in_tdata[5:3];
  assign in_item.digit_value = in_tdata[9:6];

  // Only a scan request needs room in the result register
  assign s1_go     = s1_vld_r && ((s1_item_r.op != OP_SCAN) || !out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
  end

  sss_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .req_go  (s1_go),
    .req     (s1_item_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

// ----- bench/display_scan_checker.sv -----
// Checker for the display scanner: follows requests and writes, predicts scan results, compares.
`timescale 1ns / 1ps

module display_scan_checker
  import sss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           pending,
  output int unsigned           fail_count
);

  // Segment patterns, code 15 in the top byte down to code 0 in the bottom byte.
  localparam logic [16*SEG_W-1:0] GLYPHS = {
    8'h00, 8'h00, 8'h00, 8'h02, 8'h9E, 8'h00, 8'hF6, 8'hFE,
    8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  logic [CODE_W-1:0] digits [NUM_DIGITS];
  logic [POS_W-1:0]  scan_pos;
  logic              phase;
  logic              prev_b;
  logic              prev_btn;
  blank_grp_t        mode;
  logic              blink_on;
  res_t              scan_results_q [$];

  function automatic logic blanked_slot(input blank_grp_t grp, input logic [POS_W-1:0] pos);
    case (grp)
      BLANK_ALL:  return 1'b1;
      BLANK_HIGH: return (pos == 3'd3) || (pos == 3'd4);
      BLANK_LOW:  return (pos == 3'd0) || (pos == 3'd1);
      default:    return pos == 3'd2;
    endcase
  endfunction

  task automatic predict_scan(input logic [1:0] op_bits, input logic [15:0] d);
    res_t             f;
    logic [POS_W-1:0] pos;
    logic             a, b, btn;
    logic [EVT_W-1:0] ev;
    a   = d[0];
    b   = d[1];
    btn = d[2];
    case (op_bits)
      OP_BLINK: begin
        phase = blink_on ? ~phase : 1'b1;
      end
      OP_WRITE: begin
        if (d[5:3] < NUM_DIGITS) digits[d[5:3]] = d[9:6];
      end
      OP_SCAN: begin
        pos = (scan_pos >= NUM_DIGITS) ? '0 : scan_pos;
        // Decide the pattern before the pins can force the phase high.
        if (!blanked_slot(mode, pos) || !blink_on || phase) begin
          f.segments = GLYPHS[{digits[pos], 3'b000} +: SEG_W];
        end else begin
          f.segments = '0;
        end
        f.digit_select = pos;
        scan_pos = (pos == LAST_POS) ? '0 : pos + 3'd1;
        ev = EVT_NONE;
        if (!a && !b && prev_b) ev = EVT_RIGHT;
        else if (!a && b && !prev_b) ev = EVT_LEFT;
        if (ev != EVT_NONE) phase = 1'b1;
        f.encoder_event  = ev;
        f.button_pressed = !btn && prev_btn;
        prev_b   = b;
        prev_btn = btn;
        scan_results_q.push_back(f);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      foreach (digits[i]) digits[i] = '0;
      scan_pos = '0;
      phase    = 1'b0;
      prev_b   = 1'b1;
      prev_btn = 1'b1;
      mode     = BLANK_MID;
      blink_on = 1'b0;
      scan_results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BLINK_MODE) begin
          mode = blank_grp_t'(cfg_wdata);
        end else begin
          blink_on = cfg_wdata[0];
          if (!blink_on) phase = 1'b1;
        end
      end
      if (in_tvalid && in_tready) predict_scan(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[13:0]);
        if (scan_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected scan result, tdata %h", out_tdata);
        end else begin
          want = scan_results_q.pop_front();
          if (got.segments !== want.segments || got.digit_select !== want.digit_select ||
              got.encoder_event !== want.encoder_event ||
              got.button_pressed !== want.button_pressed) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("scan result mismatch: expected seg %h sel %0d enc %0d btn %0d, got seg %h sel %0d enc %0d btn %0d",
                       want.segments, want.digit_select, want.encoder_event, want.button_pressed,
                       got.segments, got.digit_select, got.encoder_event, got.button_pressed);
            end
          end
        end
      end
    end
    pending = scan_results_q.size();
  end

endmodule

// ----- bench/seven_segment_scan_with_encoder_test.sv -----
// Top of the display scanner test: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module seven_segment_scan_with_encoder_test;
  import sss_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Quadrature walk as {a, b}: 11, 01, 00, 10.
  localparam logic [7:0] QUAD = 8'b10_00_01_11;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           pending;
  int unsigned           fail_count;
  int unsigned           gap_pct = 0;
  int unsigned           stall_pct = 0;
  logic [1:0]            enc_pos;
  logic                  btn_level;

  seven_segment_scan_with_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  display_scan_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("seven_segment_scan_with_encoder_test failed");
    $finish;
  end

  // Hold off results in random bursts while stall_pct is nonzero.
  initial begin
    out_tready <= 1'b1;
    forever begin
      if ($urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_req(input logic [1:0] op, input logic a, input logic b, input logic btn,
                          input logic [2:0] idx, input logic [3:0] val);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, val, idx, btn, b, a};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic scan_tick(input logic a, input logic b, input logic btn);
    send_req(OP_SCAN, a, b, btn, 3'($urandom), 4'($urandom));
  endtask

  task automatic blink_tick();
    send_req(OP_BLINK, 1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom), 4'($urandom));
  endtask

  task automatic write_digit(input logic [2:0] idx, input logic [3:0] val);
    send_req(OP_WRITE, 1'($urandom), 1'($urandom), 1'($urandom), idx, val);
  endtask

  // Drop valid, let every scan result drain, then let trailing requests clear the pipe.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(input logic [1:0] mode_w, input logic [1:0] en_w);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLINK_MODE;
    cfg_wdata <= mode_w;
    @(posedge clk);
    cfg_index <= CFG_BLINK_EN;
    cfg_wdata <= en_w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly clean knob turns and button presses, some pin noise, writes, blink ticks, unused ops.
  task automatic random_request();
    int unsigned pick;
    logic [1:0]  ab;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) begin
        ab = 2'($urandom);
      end else begin
        enc_pos = enc_pos + 2'($urandom_range(0, 2)) - 2'd1;
        ab = QUAD[{enc_pos, 1'b0} +: 2];
      end
      if ($urandom_range(0, 6) == 0) btn_level = ~btn_level;
      scan_tick(ab[1], ab[0], btn_level);
    end else if (pick < 70) begin
      blink_tick();
    end else if (pick < 96) begin
      write_digit(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                  4'($urandom));
    end else begin
      send_req(OP_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    logic [1:0] mode_w;
    logic [1:0] en_w;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    enc_pos   = 2'd0;
    btn_level = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: blinking off, so every digit shows.
    write_digit(3'd0, 4'd8);
    write_digit(3'd1, 4'd15);
    write_digit(3'd2, 4'd12);
    write_digit(3'd3, 4'd11);
    write_digit(3'd4, 4'd13);
    write_digit(3'd5, 4'd9);
    write_digit(3'd7, 4'd1);
    send_req(OP_UNUSED, 1'b1, 1'b1, 1'b1, 3'd7, 4'd15);
    scan_tick(1'b1, 1'b1, 1'b1);
    scan_tick(1'b0, 1'b1, 1'b1);
    scan_tick(1'b0, 1'b0, 1'b0);
    scan_tick(1'b0, 1'b0, 1'b0);
    scan_tick(1'b1, 1'b0, 1'b1);
    scan_tick(1'b0, 1'b1, 1'b1);
    blink_tick();

    // Blank everything, then let a right step relight the display.
    set_regs(BLANK_ALL, 2'd1);
    blink_tick();
    repeat (5) scan_tick(1'b1, 1'b1, 1'b1);
    scan_tick(1'b0, 1'b0, 1'b1);
    scan_tick(1'b1, 1'b1, 1'b1);
    write_digit(3'd2, 4'd0);
    scan_tick(1'b1, 1'b1, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      mode_w = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      en_w   = (ph % 2 == 0) ? 2'd1 : 2'($urandom);
      if (ph >= 10) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 10 * $urandom_range(0, 5);
        stall_pct = 10 * $urandom_range(0, 5);
      end
      set_regs(mode_w, en_w);
      repeat (135) random_request();
    end

    in_tvalid <= 1'b0;
    for (int n = 0; n < 2000 && pending != 0; n++) @(negedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("seven_segment_scan_with_encoder_test passed");
    end else begin
      $display("seven_segment_scan_with_encoder_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sss_pkg.sv
rtl/core/sss_core.sv
rtl/core/seven_segment_scan_with_encoder.sv
bench/display_scan_checker.sv
bench/seven_segment_scan_with_encoder_test.sv
